FILE: rtl/core/tbdf_pkg.sv
// Package for the timed byte delay FIFO: sizes, codes, entry and store request types.
// Shared by the channel interfaces, the entry store and the control module.
package tbdf_pkg;

    localparam int DEPTH       = 2048;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int STAMP_W     = 16;
    localparam int DELAY_W     = 15;
    localparam int BYTE_W      = 8;
    localparam int CMP_W       = (STAMP_W > DELAY_W) ? STAMP_W : DELAY_W;
    localparam int DELAY_RESET = 2000;

    // Request codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // Result status codes
    localparam logic ST_RELEASE = 1'b0;
    localparam logic ST_DROP    = 1'b1;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [DELAY_W-1:0] delay_t;
    typedef logic [BYTE_W-1:0]  byte_t;

    typedef struct packed {
        stamp_t stamp;
        byte_t  data;
    } entry_t;

    typedef struct packed {
        logic   rd_en;
        ptr_t   rd_addr0;
        ptr_t   rd_addr1;
        logic   wr_en;
        ptr_t   wr_addr;
        entry_t wr_data;
    } store_req_t;

    typedef struct packed {
        entry_t rd_data0;
        entry_t rd_data1;
    } store_rsp_t;

    // Advance a circular pointer
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/tbdf_if.sv
// Valid/ready channel interfaces: input requests, results and the delay register write.
// Depends on tbdf_pkg for field types.
interface tbdf_item_if;
    import tbdf_pkg::*;
    logic  valid;
    logic  ready;
    logic  op;
    byte_t rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface tbdf_result_if;
    import tbdf_pkg::*;
    logic  valid;
    logic  ready;
    byte_t tx_byte;
    logic  status;

    modport source (output valid, output tx_byte, output status, input ready);
    modport sink   (input valid, input tx_byte, input status, output ready);
endinterface

interface tbdf_cfg_if;
    import tbdf_pkg::*;
    logic   valid;
    logic   ready;
    delay_t delay_ticks;

    modport source (output valid, output delay_ticks, input ready);
    modport sink   (input valid, input delay_ticks, output ready);
endinterface

FILE: rtl/core/tbdf_store.sv
// Entry store: one write port and two registered read ports over DEPTH stamped bytes.
// Depends on tbdf_pkg for the entry and request types.
module tbdf_store
    import tbdf_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output store_rsp_t rsp
);

    entry_t mem [DEPTH];

    // Write the new entry, read the head and the entry after it
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rsp.rd_data0 <= mem[req.rd_addr0];
            rsp.rd_data1 <= mem[req.rd_addr1];
        end
    end

endmodule

FILE: rtl/core/tbdf_ctrl.sv
// Control for the timed byte delay FIFO: request stage, pointers, tick count, release
// decision and result register. Depends on tbdf_pkg and the channel interfaces.
module tbdf_ctrl
    import tbdf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tbdf_item_if.sink            item,
    tbdf_result_if.source        result,
    tbdf_cfg_if.sink             cfg,
    output store_req_t           store_req,
    input  store_rsp_t           store_rsp
);

    // Request stage
    logic   item_valid_reg;
    logic   item_op_reg;
    byte_t  item_byte_reg;

    // Read bookkeeping captured when the read issues
    logic   sel_next_reg;
    logic   fwd_valid_reg;
    ptr_t   fwd_addr_reg;
    entry_t fwd_entry_reg;

    // Architectural state
    stamp_t now_reg;
    ptr_t   wp_reg;
    ptr_t   rp_reg;
    cnt_t   held_reg;
    delay_t delay_reg;

    // Result register
    logic   out_valid_reg;
    byte_t  out_byte_reg;
    logic   out_status_reg;

    logic   out_free;
    logic   proc;
    logic   accept;
    entry_t rd_entry;
    entry_t head;
    stamp_t now_next;
    stamp_t age;
    logic   is_byte;
    logic   full;
    logic   do_write;
    logic   do_drop;
    logic   do_rel;
    entry_t wr_entry;
    cnt_t   ptr_span;

    // Handshake: the stage moves when the result register can take its outcome
    assign out_free   = !out_valid_reg || result.ready;
    assign proc       = item_valid_reg && out_free;
    assign item.ready = !item_valid_reg || out_free;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Pick the head entry: shift past a release that overlapped the read, forward a late write
    always_comb
    begin
        rd_entry = sel_next_reg ? store_rsp.rd_data1 : store_rsp.rd_data0;
        if (fwd_valid_reg && (fwd_addr_reg == rp_reg))
        begin
            head = fwd_entry_reg;
        end
        else
        begin
            head = rd_entry;
        end
    end

    // Decide the outcome of the staged request
    always_comb
    begin
        now_next = now_reg + 1'b1;
        age      = now_next - head.stamp;
        is_byte  = (item_op_reg == OP_BYTE);
        full     = (held_reg == CNT_W'(DEPTH));
        do_write = proc && is_byte && !full;
        do_drop  = proc && is_byte && full;
        do_rel   = proc && !is_byte && (held_reg != '0)
                   && (CMP_W'(age) >= CMP_W'(delay_reg));
        wr_entry = '{stamp: now_reg, data: item_byte_reg};
    end

    // Drive the store: read head and successor on accept, write on a stored byte
    always_comb
    begin
        store_req.rd_en    = accept;
        store_req.rd_addr0 = rp_reg;
        store_req.rd_addr1 = ptr_inc(rp_reg);
        store_req.wr_en    = do_write;
        store_req.wr_addr  = wp_reg;
        store_req.wr_data  = wr_entry;
    end

    // Hold the staged request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            sel_next_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
                sel_next_reg   <= do_rel;
                fwd_valid_reg  <= do_write;
            end
            else if (proc)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    // Capture request payload and forwarding data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_op_reg   <= item.op;
            item_byte_reg <= item.rx_byte;
            fwd_addr_reg  <= wp_reg;
            fwd_entry_reg <= wr_entry;
        end
    end

    // Advance tick count, pointers and fill count; take delay writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg   <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            held_reg  <= '0;
            delay_reg <= DELAY_W'(DELAY_RESET);
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                delay_reg <= cfg.delay_ticks;
            end
            if (proc && !is_byte)
            begin
                now_reg <= now_next;
            end
            if (do_write)
            begin
                wp_reg   <= ptr_inc(wp_reg);
                held_reg <= held_reg + 1'b1;
            end
            if (do_rel)
            begin
                rp_reg   <= ptr_inc(rp_reg);
                held_reg <= held_reg - 1'b1;
            end
        end
    end

    // Load the result register, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= do_rel || do_drop;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_byte_reg   <= do_drop ? item_byte_reg : head.data;
            out_status_reg <= do_drop ? ST_DROP : ST_RELEASE;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.tx_byte = out_byte_reg;
    assign result.status  = out_status_reg;

    // Distance from read to write pointer around the ring
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            ptr_span = CNT_W'(wp_reg) - CNT_W'(rp_reg);
        end
        else
        begin
            ptr_span = CNT_W'(DEPTH) - CNT_W'(rp_reg) + CNT_W'(wp_reg);
        end
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond store depth");

    a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == ptr_span) || ((held_reg == CNT_W'(DEPTH)) && (ptr_span == '0)))
        else $error("pointers disagree with fill count");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        do_drop |-> (held_reg == CNT_W'(DEPTH)) && !do_write)
        else $error("byte dropped while store has room");

    a_rel_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_rel |=> (held_reg == $past(held_reg) - 1'b1) && (rp_reg != $past(rp_reg)))
        else $error("release did not consume the head entry");

endmodule

FILE: rtl/core/timed_byte_delay_fifo_unit.sv
// Top level of the timed byte delay FIFO: joins the control module and the entry store.
// Depends on tbdf_pkg, the channel interfaces, tbdf_ctrl and tbdf_store.
//
//  channel  | dir | payload               | moves on
//  ---------+-----+-----------------------+---------------------------
//  item     | in  | op, rx_byte           | item.valid && item.ready
//  result   | out | tx_byte, status       | result.valid && result.ready
//  cfg      | in  | delay_ticks (15 bits) | cfg.valid && cfg.ready
//
// One request per cycle sustained while results are taken; the store is read when a request
// is taken and its outcome goes into the output register once free. The store read of the
// head and its successor at each accept lets a release follow a release in the next cycle.
// Reset clears pointers, fill count and tick count; the store itself is not cleared.
// A stalled result holds the request stage, which takes one more request meanwhile.
module timed_byte_delay_fifo_unit
    import tbdf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tbdf_item_if.sink     item,
    tbdf_result_if.source result,
    tbdf_cfg_if.sink      cfg
);

    store_req_t store_req;
    store_rsp_t store_rsp;

    tbdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg       (cfg),
        .store_req (store_req),
        .store_rsp (store_rsp)
    );

    tbdf_store u_store (
        .clk (clk),
        .req (store_req),
        .rsp (store_rsp)
    );

endmodule

FILE: tb/tb_timed_byte_delay_fifo_unit.sv
// Testbench for timed_byte_delay_fifo_unit: directed and random request streams, checked
// against a cycle-free predictor of the tick count, the circular store and its release rule.
// Depends on tbdf_pkg, the tbdf channel interfaces and the RTL of the unit.
`timescale 1ns / 1ps

module tb_timed_byte_delay_fifo_unit;
    import tbdf_pkg::*;

    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 20;
    localparam int     LIMIT_CYCLES  = 1_000_000;
    localparam delay_t DELAY_MAX     = '1;

    typedef struct packed {
        byte_t tx_byte;
        logic  status;
    } echo_t;

    logic clk;
    logic rst_n;

    tbdf_item_if   item_ch();
    tbdf_result_if echo_ch();
    tbdf_cfg_if    cfg_ch();

    timed_byte_delay_fifo_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (echo_ch),
        .cfg    (cfg_ch)
    );

    // Predicted state of the delay store
    stamp_t held_stamp [DEPTH];
    byte_t  held_data  [DEPTH];
    ptr_t   wr_ptr;
    ptr_t   rd_ptr;
    cnt_t   fill_cnt;
    stamp_t tick_now;
    delay_t delay_reg;
    echo_t  echo_expect[$];

    int err_count;
    int cycle_count;
    int hold_req;
    bit tx_idle_en;
    bit rx_idle_en;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_timed_byte_delay_fifo_unit: FAIL");
            $finish;
        end
    end

    function automatic ptr_t wrap_next(input ptr_t p);
        if (p == ptr_t'(DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Apply one accepted request to the predicted state; queue any result it causes
    function automatic void predict_echo(input logic op_v, input byte_t data_v);
        stamp_t age;
        if (op_v == OP_BYTE)
        begin
            if (fill_cnt == cnt_t'(DEPTH))
            begin
                echo_expect.push_back('{tx_byte: data_v, status: ST_DROP});
            end
            else
            begin
                held_stamp[wr_ptr] = tick_now;
                held_data[wr_ptr]  = data_v;
                wr_ptr             = wrap_next(wr_ptr);
                fill_cnt           = fill_cnt + 1'b1;
            end
        end
        else
        begin
            tick_now = tick_now + 1'b1;
            if (fill_cnt != '0)
            begin
                age = tick_now - held_stamp[rd_ptr];
                if (int'(age) >= int'(delay_reg))
                begin
                    echo_expect.push_back('{tx_byte: held_data[rd_ptr], status: ST_RELEASE});
                    rd_ptr   = wrap_next(rd_ptr);
                    fill_cnt = fill_cnt - 1'b1;
                end
            end
        end
    endfunction

    // Check results against the oldest expectation, then predict from accepted requests
    always @(posedge clk)
    begin
        echo_t head;
        if (rst_n)
        begin
            if (echo_ch.valid && echo_ch.ready)
            begin
                if (echo_expect.size() == 0)
                begin
                    $error("unexpected result: tx_byte %02h status %0b",
                           echo_ch.tx_byte, echo_ch.status);
                    err_count++;
                end
                else
                begin
                    head = echo_expect.pop_front();
                    if (head.tx_byte !== echo_ch.tx_byte)
                    begin
                        $error("tx_byte: expected %02h, actual %02h",
                               head.tx_byte, echo_ch.tx_byte);
                        err_count++;
                    end
                    if (head.status !== echo_ch.status)
                    begin
                        $error("status: expected %0b, actual %0b", head.status, echo_ch.status);
                        err_count++;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                predict_echo(item_ch.op, item_ch.rx_byte);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                delay_reg = cfg_ch.delay_ticks;
            end
        end
    end

    // Result ready: random stall bursts plus the long hold the tests ask for
    initial
    begin
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        echo_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                echo_ch.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                echo_ch.ready <= 1'b0;
            end
            else if (rx_idle_en && ($urandom_range(0, 7) == 0))
            begin
                gap_left = $urandom_range(1, 18) - 1;
                echo_ch.ready <= 1'b0;
            end
            else
            begin
                echo_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one request, after an optional idle burst, and hold it until taken
    task automatic send_item(input logic op_v, input byte_t data_v);
        if (tx_idle_en && ($urandom_range(0, 3) == 0))
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.op      <= op_v;
        item_ch.rx_byte <= data_v;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(OP_TICK, byte_t'($urandom));
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_results();
        item_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (echo_expect.size() != 0);
    endtask

    // Drain, then idle for SETTLE_CYCLES so the pipeline clears
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_delay(input delay_t v);
        settle();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.delay_ticks <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset value of the delay holds bytes past a short wait; a shorter delay lets them go
    task automatic test_reset_delay();
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_ticks(20);
        write_delay(delay_t'(20));
        send_ticks(2);
    endtask

    // Zero delay: empty-store tick, then each tick releases one held byte, oldest first
    task automatic test_zero_delay();
        write_delay('0);
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, 8'hA5);
        send_item(OP_BYTE, 8'h5A);
        send_ticks(3);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, 8'h80);
        send_ticks(1);
    endtask

    // Short delay: ticks that find the head too young, then releases in order
    task automatic test_short_delay();
        write_delay(delay_t'(3));
        send_item(OP_BYTE, 8'h3C);
        send_ticks(1);
        send_item(OP_BYTE, 8'hC3);
        send_ticks(5);
        write_delay(delay_t'(1));
        send_item(OP_BYTE, 8'h7E);
        send_ticks(2);
    endtask

    // Hold results off long enough to stall requests, then pause until all results arrive
    task automatic test_backpressure();
        write_delay('0);
        repeat (24) send_item(OP_BYTE, byte_t'($urandom));
        hold_req = 250;
        send_ticks(32);
        wait_results();
        repeat (8) send_item(OP_BYTE, byte_t'($urandom));
        send_ticks(10);
    endtask

    // Largest delay holds a byte through many ticks; a shorter one then lets it go
    task automatic test_max_delay();
        write_delay(DELAY_MAX);
        send_item(OP_BYTE, 8'h96);
        send_ticks(40);
        write_delay(delay_t'(40));
        send_ticks(2);
    endtask

    // Full store: fill without ticks, drop the overflow, reopen one slot, refill and drop
    task automatic test_full_store();
        int room;
        write_delay(DELAY_MAX);
        room = DEPTH - int'(fill_cnt);
        tx_idle_en = 1'b0;
        repeat (room) send_item(OP_BYTE, byte_t'($urandom));
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, byte_t'($urandom));
        write_delay('0);
        send_ticks(1);
        send_item(OP_BYTE, 8'h3C);
        send_item(OP_BYTE, 8'hC3);
        send_ticks(4);
        tx_idle_en = 1'b1;
    endtask

    // Random mixes of bytes and ticks under a series of delay settings
    task automatic test_random_mix();
        delay_t phase_delay;
        int     pct_byte;
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin phase_delay = '0;                               pct_byte = 50; end
                1: begin phase_delay = delay_t'(1);                      pct_byte = 50; end
                2: begin phase_delay = delay_t'($urandom_range(2, 15));  pct_byte = 40; end
                3: begin phase_delay = delay_t'($urandom);               pct_byte = 50; end
                4: begin phase_delay = delay_t'($urandom_range(0, 3));   pct_byte = 30; end
                5: begin phase_delay = DELAY_MAX;                        pct_byte = 40; end
                default:
                begin
                    phase_delay = delay_t'($urandom_range(0, 2));
                    pct_byte    = 35;
                end
            endcase
            write_delay(phase_delay);
            // Run the last phase with no idling on either side
            if (ph == 6)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            repeat (50)
            begin
                if ($urandom_range(1, 100) <= pct_byte)
                begin
                    send_item(OP_BYTE, byte_t'($urandom));
                end
                else
                begin
                    send_item(OP_TICK, byte_t'($urandom));
                end
            end
        end
    endtask

    // Reset, run the tests in turn, report
    initial
    begin
        err_count   = 0;
        cycle_count = 0;
        hold_req    = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        wr_ptr      = '0;
        rd_ptr      = '0;
        fill_cnt    = '0;
        tick_now    = '0;
        delay_reg   = delay_t'(DELAY_RESET);

        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.op         <= OP_TICK;
        item_ch.rx_byte    <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.delay_ticks <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_delay();
        test_zero_delay();
        test_short_delay();
        test_backpressure();
        test_max_delay();
        test_full_store();
        test_random_mix();

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if ((err_count == 0) && (echo_expect.size() == 0))
        begin
            $display("tb_timed_byte_delay_fifo_unit: PASS");
        end
        else
        begin
            $display("tb_timed_byte_delay_fifo_unit: FAIL");
        end
        $finish;
    end

endmodule
